// File: hw/rtl/two_dim_parity_checker_top_assert.svh
// Assertion macros for the two-dimensional parity checker.
`ifndef TWO_DIM_PARITY_CHECKER_TOP_ASSERT_SVH
`define TWO_DIM_PARITY_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TDPC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tdpc_pkg.sv
// Shared types and constants of the two-dimensional parity checker.
package tdpc_pkg;

    localparam int unsigned MAX_SIZE_DEF = 128;
    localparam int unsigned DEFAULT_SIZE = 8;
    localparam int unsigned CFG_WIDTH    = 8;
    localparam int unsigned FIX_WIDTH    = 8;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_CORRUPT = 2'd1,
        VERDICT_FIX     = 2'd2
    } t_verdict;

endpackage

// File: hw/rtl/two_dim_parity_checker_top.sv
// Two-dimensional parity checker: top level with column parity memory.
//
// Usage:
//   Configuration: i_cfg_we / i_cfg_wdata write the matrix size (0 acts as 1,
//   values above MAX_SIZE act as MAX_SIZE). A write restarts the matrix; write
//   only while the block is idle.
//   Input: one matrix bit per beat on i_valid / o_ready / i_data_bit, row-major.
//   Output: one verdict beat per matrix on o_valid / i_ready with o_verdict,
//   o_fix_row, o_fix_col (1-based position, zero unless a single bit to flip).
//   Throughput: one bit per cycle while o_ready is high. Column parities live in a
//   one-port-write, one-port-read memory with a registered read; each bit is a
//   read-modify-write that spans two stages, so beats flow back to back.
//   Order: the final bit passes stage 1, then the output register raises o_valid.
//   Stall: the output register holds a verdict while i_ready is low; the block
//   keeps taking bits until a second verdict would have nowhere to go, then
//   drops o_ready until the first one is taken.
//   Reset: synchronous, active low; size returns to 8 (or MAX_SIZE if smaller)
//   and a new matrix starts. The column memory needs no clearing pass: the
//   first row of each matrix overwrites it.
`include "two_dim_parity_checker_top_assert.svh"

module two_dim_parity_checker_top #(
    parameter int unsigned MAX_SIZE = tdpc_pkg::MAX_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tdpc_pkg::CFG_WIDTH-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_data_bit,
    output logic                             o_valid,
    input  logic                             i_ready,
    output tdpc_pkg::t_verdict               o_verdict,
    output logic [tdpc_pkg::FIX_WIDTH-1:0]   o_fix_row,
    output logic [tdpc_pkg::FIX_WIDTH-1:0]   o_fix_col
);
    import tdpc_pkg::*;

    localparam int unsigned PW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned RST_SIZE = (DEFAULT_SIZE < MAX_SIZE) ? DEFAULT_SIZE : MAX_SIZE;
    localparam logic [PW-1:0] RST_LAST = PW'(RST_SIZE - 1);

    // stage 0: position tracking
    logic [PW-1:0] r_last_idx;
    logic [PW-1:0] n_last_idx;
    logic [PW-1:0] r_row_pos;
    logic [PW-1:0] r_col_pos;
    logic          col_last;
    logic          row_last;
    logic          in_acc;

    // stage 1: read-modify-write of the column parity
    logic          r_s1_valid;
    logic          r_s1_bit;
    logic [PW-1:0] r_s1_row;
    logic [PW-1:0] r_s1_col;
    logic          r_s1_first;
    logic          r_s1_last_row;
    logic          r_s1_last_col;
    logic          s1_final;
    logic          s1_stall;
    logic          s1_adv;

    logic          r_col_par_mem [MAX_SIZE];
    logic          r_rd_data;
    logic          r_fwd_hit;
    logic          r_fwd_data;
    logic          rd_par;
    logic          colp;

    // matrix accumulators
    logic          r_row_par;
    logic [1:0]    r_odd_rows;
    logic [1:0]    r_odd_cols;
    logic [PW-1:0] r_last_odd_row;
    logic [PW-1:0] r_last_odd_col;
    logic          n_row_par;
    logic [1:0]    n_odd_rows;
    logic [1:0]    n_odd_cols;
    logic [PW-1:0] n_last_odd_row;
    logic [PW-1:0] n_last_odd_col;
    logic          odd_row_evt;
    logic          odd_col_evt;

    // verdict and output register
    t_verdict               n_verdict;
    logic [FIX_WIDTH-1:0]   n_fix_row;
    logic [FIX_WIDTH-1:0]   n_fix_col;
    logic                   r_out_valid;
    t_verdict               r_out_verdict;
    logic [FIX_WIDTH-1:0]   r_out_fix_row;
    logic [FIX_WIDTH-1:0]   r_out_fix_col;

    // ---------------- handshake ----------------
    assign s1_final = r_s1_last_row && r_s1_last_col;
    assign s1_stall = r_s1_valid && s1_final && r_out_valid && !i_ready;
    assign s1_adv   = r_s1_valid && !s1_stall;
    assign o_ready  = !s1_stall;
    assign in_acc   = i_valid && o_ready;

    // ---------------- configuration ----------------
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_last_idx = '0;
        end else if (32'(i_cfg_wdata) > MAX_SIZE) begin
            n_last_idx = PW'(MAX_SIZE - 1);
        end else begin
            n_last_idx = PW'(32'(i_cfg_wdata) - 32'd1);
        end
    end

    // ---------------- stage 0 ----------------
    assign col_last = (r_col_pos == r_last_idx);
    assign row_last = (r_row_pos == r_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= RST_LAST;
            r_row_pos  <= '0;
            r_col_pos  <= '0;
        end else if (i_cfg_we) begin
            r_last_idx <= n_last_idx;
            r_row_pos  <= '0;
            r_col_pos  <= '0;
        end else if (in_acc) begin
            if (col_last) begin
                r_col_pos <= '0;
                r_row_pos <= row_last ? '0 : r_row_pos + PW'(1);
            end else begin
                r_col_pos <= r_col_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_bit      <= i_data_bit;
            r_s1_row      <= r_row_pos;
            r_s1_col      <= r_col_pos;
            r_s1_first    <= (r_row_pos == '0);
            r_s1_last_row <= row_last;
            r_s1_last_col <= col_last;
        end
    end

    // ---------------- column parity memory ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data  <= r_col_par_mem[r_col_pos];
            // write in the same cycle to the column being read: take new data
            r_fwd_hit  <= s1_adv && (r_s1_col == r_col_pos);
            r_fwd_data <= colp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_col_par_mem[r_s1_col] <= colp;
        end
    end

    assign rd_par = r_fwd_hit ? r_fwd_data : r_rd_data;
    // first row overwrites, which clears the store for a new matrix
    assign colp   = r_s1_first ? r_s1_bit : (rd_par ^ r_s1_bit);

    // ---------------- stage 1 accumulators ----------------
    assign n_row_par   = r_row_par ^ r_s1_bit;
    assign odd_row_evt = r_s1_last_col && n_row_par;
    assign odd_col_evt = r_s1_last_row && colp;

    always_comb begin
        n_odd_rows     = r_odd_rows;
        n_odd_cols     = r_odd_cols;
        n_last_odd_row = r_last_odd_row;
        n_last_odd_col = r_last_odd_col;
        if (odd_row_evt) begin
            n_last_odd_row = r_s1_row;
            if (r_odd_rows != 2'd2) begin
                n_odd_rows = r_odd_rows + 2'd1;
            end
        end
        if (odd_col_evt) begin
            n_last_odd_col = r_s1_col;
            if (r_odd_cols != 2'd2) begin
                n_odd_cols = r_odd_cols + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_row_par      <= 1'b0;
            r_odd_rows     <= '0;
            r_odd_cols     <= '0;
            r_last_odd_row <= '0;
            r_last_odd_col <= '0;
        end else if (s1_adv) begin
            if (s1_final) begin
                r_row_par      <= 1'b0;
                r_odd_rows     <= '0;
                r_odd_cols     <= '0;
                r_last_odd_row <= '0;
                r_last_odd_col <= '0;
            end else begin
                r_row_par      <= r_s1_last_col ? 1'b0 : n_row_par;
                r_odd_rows     <= n_odd_rows;
                r_odd_cols     <= n_odd_cols;
                r_last_odd_row <= n_last_odd_row;
                r_last_odd_col <= n_last_odd_col;
            end
        end
    end

    // ---------------- verdict ----------------
    always_comb begin
        n_verdict = VERDICT_FIX;
        n_fix_row = '0;
        n_fix_col = '0;
        if (n_odd_rows == 2'd0 && n_odd_cols == 2'd0) begin
            n_verdict = VERDICT_OK;
        end else if (n_odd_rows == 2'd2 || n_odd_cols == 2'd2 ||
                     n_odd_rows == 2'd0 || n_odd_cols == 2'd0) begin
            n_verdict = VERDICT_CORRUPT;
        end else begin
            n_verdict = VERDICT_FIX;
            n_fix_row = FIX_WIDTH'(n_last_odd_row) + FIX_WIDTH'(1);
            n_fix_col = FIX_WIDTH'(n_last_odd_col) + FIX_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_final) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_final) begin
            r_out_verdict <= n_verdict;
            r_out_fix_row <= n_fix_row;
            r_out_fix_col <= n_fix_col;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;
    assign o_fix_row = r_out_fix_row;
    assign o_fix_col = r_out_fix_col;

    // ---------------- assertions ----------------
    `TDPC_ASSERT_IMPL(a_pos_in_range, 1'b1,
        (r_col_pos <= r_last_idx) && (r_row_pos <= r_last_idx),
        "matrix position beyond configured size")
    `TDPC_ASSERT_NEXT(a_final_gives_verdict, s1_adv && s1_final, r_out_valid,
        "final bit retired without a verdict beat")
    `TDPC_ASSERT_IMPL(a_stall_only_when_full, r_s1_valid && !s1_adv,
        r_out_valid && !i_ready, "stage 1 held while output can drain")
    `TDPC_ASSERT_IMPL(a_fix_zero_unless_flip, r_out_valid && (r_out_verdict != VERDICT_FIX),
        (r_out_fix_row == '0) && (r_out_fix_col == '0),
        "fix position set on a verdict that names no bit")

endmodule

// File: verif/testbench.sv
// Testbench for the two-dimensional parity checker: predicts each matrix verdict and compares.
`timescale 1ns / 1ps

module testbench;
    import tdpc_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        t_verdict             verdict;
        logic [FIX_WIDTH-1:0] fix_row;
        logic [FIX_WIDTH-1:0] fix_col;
    } t_verdict_beat;

    // Tracks the parity state of the current matrix and queues the verdict of each one.
    class verdict_scoreboard;
        logic [CFG_WIDTH-1:0] size_reg;
        bit                   col_par [MAX_SIZE_DEF];
        bit                   row_acc;
        int unsigned          row_pos, col_pos;
        int unsigned          odd_rows, odd_cols;
        int unsigned          last_odd_row, last_odd_col;
        t_verdict_beat        pending [$];
        int unsigned          errors;

        function new();
            size_reg = DEFAULT_SIZE;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            row_acc      = 1'b0;
            row_pos      = 0;
            col_pos      = 0;
            odd_rows     = 0;
            odd_cols     = 0;
            last_odd_row = 0;
            last_odd_col = 0;
        endfunction

        function int unsigned eff_size();
            if (size_reg == 0)
                return 1;
            if (size_reg > MAX_SIZE_DEF)
                return MAX_SIZE_DEF;
            return size_reg;
        endfunction

        function void write_size(logic [CFG_WIDTH-1:0] value);
            size_reg = value;
            restart();
        endfunction

        function void note_bit(bit b);
            int unsigned   n = eff_size();
            bit            last_r, last_c, cp;
            t_verdict_beat v;
            last_r = (row_pos + 1 == n);
            last_c = (col_pos + 1 == n);
            // first row of a matrix overwrites the column store
            cp = (row_pos == 0) ? b : (col_par[col_pos] ^ b);
            col_par[col_pos] = cp;
            if (last_r && cp) begin
                if (odd_cols < 2)
                    odd_cols++;
                last_odd_col = col_pos;
            end
            row_acc ^= b;
            if (last_c) begin
                if (row_acc) begin
                    if (odd_rows < 2)
                        odd_rows++;
                    last_odd_row = row_pos;
                end
                row_acc = 1'b0;
            end
            if (!last_c) begin
                col_pos++;
                return;
            end
            col_pos = 0;
            if (!last_r) begin
                row_pos++;
                return;
            end
            v.fix_row = '0;
            v.fix_col = '0;
            if (odd_rows == 0 && odd_cols == 0) begin
                v.verdict = VERDICT_OK;
            end else if (odd_rows > 1 || odd_cols > 1 || odd_rows + odd_cols == 1) begin
                v.verdict = VERDICT_CORRUPT;
            end else begin
                v.verdict = VERDICT_FIX;
                v.fix_row = FIX_WIDTH'(last_odd_row + 1);
                v.fix_col = FIX_WIDTH'(last_odd_col + 1);
            end
            pending.insert(pending.size(), v);
            restart();
        endfunction

        function void check_verdict(t_verdict verdict, logic [FIX_WIDTH-1:0] fix_row,
                                    logic [FIX_WIDTH-1:0] fix_col);
            t_verdict_beat want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected verdict beat: verdict %0d row %0d col %0d",
                             verdict, fix_row, fix_col);
                return;
            end
            want = pending.pop_front();
            if (want.verdict !== verdict || want.fix_row !== fix_row ||
                want.fix_col !== fix_col) begin
                errors++;
                if (errors <= 10)
                    $display("verdict mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.verdict, want.fix_row, want.fix_col,
                             verdict, fix_row, fix_col);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_WIDTH-1:0] i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 i_data_bit  = 1'b0;
    logic                 i_ready     = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    t_verdict             o_verdict;
    logic [FIX_WIDTH-1:0] o_fix_row;
    logic [FIX_WIDTH-1:0] o_fix_col;

    verdict_scoreboard sb = new();
    bit                cells [$];
    int unsigned       src_idle_pct   = 0;
    int unsigned       sink_stall_pct = 0;

    two_dim_parity_checker_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_bit  (i_data_bit),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_verdict   (o_verdict),
        .o_fix_row   (o_fix_row),
        .o_fix_col   (o_fix_col)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_bit(i_data_bit);
            if (o_valid && i_ready)
                sb.check_verdict(o_verdict, o_fix_row, o_fix_col);
        end
    end

    // Matrix with all row and column parities even.
    function automatic void build_even(int n);
        bit p;
        cells.delete();
        for (int i = 0; i < n * n; i++)
            cells.insert(cells.size(), 1'($urandom_range(1)));
        for (int r = 0; r < n - 1; r++) begin
            p = 1'b0;
            for (int c = 0; c < n - 1; c++)
                p ^= cells[r * n + c];
            cells[r * n + n - 1] = p;
        end
        for (int c = 0; c < n; c++) begin
            p = 1'b0;
            for (int r = 0; r < n - 1; r++)
                p ^= cells[r * n + c];
            cells[(n - 1) * n + c] = p;
        end
    endfunction

    function automatic void flip(int n, int r, int c);
        cells[r * n + c] = !cells[r * n + c];
    endfunction

    task automatic set_phase(int unsigned src_pct, int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Entered and left right after a rising edge; valid stays up between back-to-back beats.
    task automatic send_bit(bit b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_data_bit <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic send_cells(int count);
        for (int i = 0; i < count; i++)
            send_bit(cells[i]);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(logic [CFG_WIDTH-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_size(value);
    endtask

    task automatic send_even(int n, int flips);
        build_even(n);
        for (int k = 0; k < flips; k++)
            flip(n, $urandom_range(n - 1), $urandom_range(n - 1));
        send_cells(n * n);
    endtask

    initial begin
        int unsigned n;
        int unsigned random_bits;
        int unsigned kind;
        int unsigned flips;
        int unsigned part;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size first
        set_phase(0, 0);
        build_even(8);
        send_cells(64);
        build_even(8);
        flip(8, 3, 5);
        send_cells(64);
        // three odd rows and columns, counts saturate
        build_even(8);
        flip(8, 0, 0);
        flip(8, 1, 1);
        flip(8, 2, 2);
        send_cells(64);
        // two odd columns, no odd row
        build_even(8);
        flip(8, 2, 1);
        flip(8, 2, 6);
        send_cells(64);

        write_size(8'd0);               // acts as 1
        cells = '{1'b0};
        send_cells(1);
        cells = '{1'b1};
        send_cells(1);
        write_size(8'd1);
        cells = '{1'b1};
        send_cells(1);
        write_size(8'd2);
        build_even(2);
        flip(2, 1, 0);
        send_cells(4);
        // one odd row, three odd columns
        write_size(8'd3);
        build_even(3);
        flip(3, 0, 0);
        flip(3, 0, 1);
        flip(3, 0, 2);
        send_cells(9);

        // size change abandons a partly sent matrix
        write_size(8'd4);
        build_even(4);
        send_cells(7);
        write_size(8'd3);
        build_even(3);
        flip(3, 2, 0);
        send_cells(9);

        // largest size and a clamped one, each left after a row wrap
        write_size(CFG_WIDTH'(MAX_SIZE_DEF));
        build_even(MAX_SIZE_DEF);
        send_cells(MAX_SIZE_DEF + 3);
        write_size(8'd255);             // clamps to the largest size
        build_even(MAX_SIZE_DEF);
        send_cells(MAX_SIZE_DEF + 5);

        // random matrices, mostly well formed with few flipped bits
        random_bits = 0;
        write_size(8'd5);
        while (random_bits < 650) begin
            case ((random_bits / 150) % 4)
                0: set_phase(0, 0);
                1: set_phase(83, 0);
                2: set_phase(0, 83);
                default: set_phase(35, 35);
            endcase
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(9) == 0)
                    write_size(CFG_WIDTH'($urandom_range(7, 16)));
                else
                    write_size(CFG_WIDTH'($urandom_range(0, 6)));
            end
            n = sb.eff_size();
            kind = $urandom_range(99);
            if (kind < 70) begin
                case ($urandom_range(5))
                    0: flips = 0;
                    1, 2, 3: flips = 1;
                    4: flips = 2;
                    default: flips = 3 + $urandom_range(3);
                endcase
                send_even(n, flips);
                random_bits += n * n;
            end else if (kind < 85 || n == 1) begin
                cells.delete();
                for (int i = 0; i < n * n; i++)
                    cells.insert(cells.size(), 1'($urandom_range(1)));
                send_cells(n * n);
                random_bits += n * n;
            end else begin
                part = $urandom_range(1, n * n - 1);
                build_even(n);
                send_cells(part);
                random_bits += part;
                write_size(CFG_WIDTH'($urandom_range(0, 6)));
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
